// ----- rtl/fcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsc_pkg
// Shared constants and types for the front-coding size counter.
// ----------------------------------------------------------------------------
package fcsc_pkg;

   // default longest string kept in the character store
   localparam int MAX_LEN_DEFAULT = 256;

   // entries in the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   localparam int CHAR_W  = 8;
   localparam int FIELD_W = 9;
   localparam int TOTAL_W = 32;

   // classification of one accepted beat, handed from front to back
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              start;
      logic              in_range;
      logic              cmp_ok;
      logic              has_prev;
      logic              overflow;
   } fcsc_item_type;

   localparam int ITEM_W = $bits(fcsc_item_type);

endpackage

// ----- rtl/fcsc_ram.sv -----
// ----------------------------------------------------------------------------
// fcsc_ram
// Generic single-clock RAM, one write and one read port, registered
// read-first output.
// ----------------------------------------------------------------------------
module fcsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read; a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fcsc_front.sv -----
// ----------------------------------------------------------------------------
// fcsc_front
// Accepts character beats, tracks string position, reads and overwrites the
// stored previous character and classifies each beat for the back end.
// ----------------------------------------------------------------------------
module fcsc_front #(
   parameter int MAX_LEN = fcsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [7:0]                                 req_char_code,
   input  logic                                       req_last_of_string,
   input  logic                                       req_starts_set,
   input  logic [$clog2(fcsc_pkg::QUEUE_DEPTH+1)-1:0] q_count,
   output logic                                       push_valid,
   output fcsc_pkg::fcsc_item_type                    push_item,
   output logic [fcsc_pkg::CHAR_W-1:0]                push_prev_char,
   output logic [$clog2(MAX_LEN+1)-1:0]               push_len
);

   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int AW    = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(fcsc_pkg::QUEUE_DEPTH + 1);

   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] prev_len_ff, prev_len_in;
   logic          has_prev_ff, has_prev_in;
   logic          ovf_ff, ovf_in;
   logic          stage_valid_ff;
   fcsc_pkg::fcsc_item_type stage_item_ff, item_in;
   logic [LW-1:0] stage_len_ff;

   logic          accept;
   logic [LW-1:0] pos_eff, pos_next;
   logic          has_prev_eff, ovf_eff, in_range;

   // hold off while the queue cannot take the beat in flight plus this one
   assign req_stall = (q_count == CNT_W'(fcsc_pkg::QUEUE_DEPTH)) ||
                      ((q_count == CNT_W'(fcsc_pkg::QUEUE_DEPTH - 1)) && stage_valid_ff);
   assign accept = req_valid && !req_stall;

   // classify the beat: a set start begins a fresh string with no predecessor
   always_comb begin
      pos_eff      = req_starts_set ? '0 : pos_ff;
      has_prev_eff = req_starts_set ? 1'b0 : has_prev_ff;
      ovf_eff      = req_starts_set ? 1'b0 : ovf_ff;
      in_range     = pos_eff < LW'(MAX_LEN);
      pos_next     = in_range ? pos_eff + LW'(1) : pos_eff;

      item_in.char_code = req_char_code;
      item_in.last      = req_last_of_string;
      item_in.start     = req_starts_set;
      item_in.in_range  = in_range;
      item_in.cmp_ok    = in_range && has_prev_eff && (pos_eff < prev_len_ff);
      item_in.has_prev  = has_prev_eff;
      item_in.overflow  = ovf_eff || !in_range;

      pos_in      = pos_ff;
      prev_len_in = prev_len_ff;
      has_prev_in = has_prev_ff;
      ovf_in      = ovf_ff;
      if (accept) begin
         if (req_last_of_string) begin
            pos_in      = '0;
            prev_len_in = pos_next;
            has_prev_in = 1'b1;
            ovf_in      = 1'b0;
         end else begin
            pos_in      = pos_next;
            has_prev_in = has_prev_eff;
            ovf_in      = item_in.overflow;
         end
      end
   end

   // advance string state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         prev_len_ff    <= '0;
         has_prev_ff    <= 1'b0;
         ovf_ff         <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         prev_len_ff    <= prev_len_in;
         has_prev_ff    <= has_prev_in;
         ovf_ff         <= ovf_in;
         stage_valid_ff <= accept;
      end
   end

   // hold the classified beat while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= item_in;
         stage_len_ff  <= pos_next;
      end
   end

   // read the old character and overwrite it in the same cycle
   fcsc_ram #(
      .WIDTH (fcsc_pkg::CHAR_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && in_range),
      .wr_addr (pos_eff[AW-1:0]),
      .wr_data (req_char_code),
      .rd_en   (accept && in_range),
      .rd_addr (pos_eff[AW-1:0]),
      .rd_data (push_prev_char)
   );

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;
   assign push_len   = stage_len_ff;

endmodule

// ----- rtl/fcsc_queue.sv -----
// ----------------------------------------------------------------------------
// fcsc_queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fcsc_queue #(
   parameter int WIDTH = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   input  logic [WIDTH-1:0]                           push_data,
   input  logic                                       pop,
   output logic                                       pop_valid,
   output logic [WIDTH-1:0]                           pop_data,
   output logic [$clog2(fcsc_pkg::QUEUE_DEPTH+1)-1:0] count
);

   localparam int DEPTH = fcsc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_data  = data_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/fcsc_back.sv -----
// ----------------------------------------------------------------------------
// fcsc_back
// Compares each character with its predecessor, counts the shared prefix,
// prices each finished string and keeps the saturating set total.
// ----------------------------------------------------------------------------
module fcsc_back #(
   parameter int MAX_LEN = fcsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  fcsc_pkg::fcsc_item_type            q_item,
   input  logic [fcsc_pkg::CHAR_W-1:0]        q_prev_char,
   input  logic [$clog2(MAX_LEN+1)-1:0]       q_len,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fcsc_pkg::FIELD_W-1:0]       rsp_string_cost,
   output logic [fcsc_pkg::FIELD_W-1:0]       rsp_shared_prefix,
   output logic [fcsc_pkg::TOTAL_W-1:0]       rsp_running_total,
   output logic                               rsp_too_long,
   output logic                               rsp_total_saturated
);

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int CW  = (LW + 1 > fcsc_pkg::FIELD_W) ? LW + 1 : fcsc_pkg::FIELD_W;
   localparam int TW  = fcsc_pkg::TOTAL_W;

   logic          match_ff, match_in;
   logic [LW-1:0] prefix_ff, prefix_in;
   logic [TW-1:0] sum_ff, sum_in;
   logic          rsp_valid_ff;
   logic [fcsc_pkg::FIELD_W-1:0] cost_ff, shared_ff;
   logic [TW-1:0] total_ff;
   logic          too_long_ff, sat_ff;

   logic          match_eff, hit, match_next, emit;
   logic [LW-1:0] prefix_eff, prefix_next;
   logic [TW-1:0] sum_eff, sum_new;
   logic [CW-1:0] len_w, shared_w, cost_w;
   logic [TW:0]   sum_wide;

   // take a beat whenever the result register is free or being drained
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign emit  = q_pop && q_item.last;

   // prefix match and string pricing
   always_comb begin
      match_eff   = q_item.start ? 1'b1 : match_ff;
      prefix_eff  = q_item.start ? '0 : prefix_ff;
      sum_eff     = q_item.start ? '0 : sum_ff;
      hit         = q_item.in_range && match_eff && q_item.cmp_ok &&
                    (q_prev_char == q_item.char_code);
      prefix_next = hit ? prefix_eff + LW'(1) : prefix_eff;
      match_next  = q_item.in_range ? hit : match_eff;

      len_w    = CW'(q_len);
      shared_w = q_item.has_prev ? CW'(prefix_next) : '0;
      cost_w   = q_item.has_prev ? (CW'(1) + len_w - shared_w) : len_w;
      sum_wide = {1'b0, sum_eff} + (TW + 1)'(cost_w);
      sum_new  = sum_wide[TW] ? '1 : sum_wide[TW-1:0];

      match_in  = match_ff;
      prefix_in = prefix_ff;
      sum_in    = sum_ff;
      if (q_pop) begin
         if (q_item.last) begin
            match_in  = 1'b1;
            prefix_in = '0;
            sum_in    = sum_new;
         end else begin
            match_in  = match_next;
            prefix_in = prefix_next;
            sum_in    = sum_eff;
         end
      end
   end

   // advance match state and the result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff     <= 1'b1;
         prefix_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         match_ff  <= match_in;
         prefix_ff <= prefix_in;
         sum_ff    <= sum_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (emit) begin
         cost_ff     <= cost_w[fcsc_pkg::FIELD_W-1:0];
         shared_ff   <= shared_w[fcsc_pkg::FIELD_W-1:0];
         total_ff    <= sum_new;
         too_long_ff <= q_item.overflow;
         sat_ff      <= &sum_new;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_string_cost     = cost_ff;
   assign rsp_shared_prefix   = shared_ff;
   assign rsp_running_total   = total_ff;
   assign rsp_too_long        = too_long_ff;
   assign rsp_total_saturated = sat_ff;

endmodule

// ----- rtl/front_coding_size_counter.sv -----
// Beats pass the front stage register and the queue; results are registered.
// Throughput: one character per cycle; the front stalls only when the
// four-entry queue plus the beat waiting on the store read are full.
// The store read and write at the current position set the front pace.
// Reset clears all control state; the character store is not cleared.
// ----------------------------------------------------------------------------
// front_coding_size_counter
// Front-coding cost counter: prefix sharing, string cost and set total.
// ----------------------------------------------------------------------------
module front_coding_size_counter #(
   parameter int MAX_LEN = fcsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_last_of_string,
   input  logic                         req_starts_set,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [8:0]                   rsp_string_cost,
   output logic [8:0]                   rsp_shared_prefix,
   output logic [31:0]                  rsp_running_total,
   output logic                         rsp_too_long,
   output logic                         rsp_total_saturated
);

   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int CNT_W = $clog2(fcsc_pkg::QUEUE_DEPTH + 1);
   localparam int QW    = LW + fcsc_pkg::CHAR_W + fcsc_pkg::ITEM_W;

   logic                              push_valid, q_valid, q_pop;
   fcsc_pkg::fcsc_item_type           push_item, q_item;
   logic [fcsc_pkg::CHAR_W-1:0]       push_prev_char, q_prev_char;
   logic [LW-1:0]                     push_len, q_len;
   logic [QW-1:0]                     q_data;
   logic [CNT_W-1:0]                  q_count;

   fcsc_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_last_of_string (req_last_of_string),
      .req_starts_set     (req_starts_set),
      .q_count            (q_count),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .push_prev_char     (push_prev_char),
      .push_len           (push_len)
   );

   fcsc_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_len, push_prev_char, push_item}),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .count     (q_count)
   );

   // unpack the queued beat
   assign q_item      = q_data[fcsc_pkg::ITEM_W-1:0];
   assign q_prev_char = q_data[fcsc_pkg::ITEM_W +: fcsc_pkg::CHAR_W];
   assign q_len       = q_data[QW-1 -: LW];

   fcsc_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_prev_char         (q_prev_char),
      .q_len               (q_len),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_string_cost     (rsp_string_cost),
      .rsp_shared_prefix   (rsp_shared_prefix),
      .rsp_running_total   (rsp_running_total),
      .rsp_too_long        (rsp_too_long),
      .rsp_total_saturated (rsp_total_saturated)
   );

   // every accepted beat reaches the queue in the next cycle
   a_accept_to_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> push_valid)
      else $error("accepted beat did not reach the queue");

   // the queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> ((q_count != CNT_W'(fcsc_pkg::QUEUE_DEPTH)) || q_pop))
      else $error("push into a full queue");

   // occupancy stays within depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(fcsc_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

// ----- tb/front_coding_size_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_coding_size_counter_tb
// Self-checking bench for the front-coding size counter. Character beats are
// queued up front and driven on a valid/stall channel with random gaps.
// Every accepted beat runs through a local cost predictor. Each result beat
// is checked against the oldest predicted result. The receiver stalls in
// random bursts.
// ----------------------------------------------------------------------------
module front_coding_size_counter_tb;

   localparam int CHAR_W       = fcsc_pkg::CHAR_W;
   localparam int FIELD_W      = fcsc_pkg::FIELD_W;
   localparam int TOTAL_W      = fcsc_pkg::TOTAL_W;
   localparam int STORE_DEPTH  = fcsc_pkg::MAX_LEN_DEFAULT;
   localparam int RANDOM_ITEMS = 2000;
   localparam int TAIL_ITEMS   = 200;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [CHAR_W-1:0] code;
      bit                last;
      bit                start;
      bit                hold_until_empty;
   } char_beat_type;

   typedef struct packed {
      logic [FIELD_W-1:0] cost;
      logic [FIELD_W-1:0] prefix;
      logic [TOTAL_W-1:0] total;
      logic               too_long;
      logic               saturated;
   } cost_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_char_code;
   logic                 req_last_of_string;
   logic                 req_starts_set;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [8:0]           rsp_string_cost;
   logic [8:0]           rsp_shared_prefix;
   logic [31:0]          rsp_running_total;
   logic                 rsp_too_long;
   logic                 rsp_total_saturated;

   // stimulus and expectation stores
   char_beat_type        pending_chars[$];
   cost_result_type      cost_expect_q[$];
   logic [CHAR_W-1:0]    shadow_string[$];

   // predictor state
   logic [CHAR_W-1:0]    prior_chars[STORE_DEPTH];
   int unsigned          prior_len;
   int unsigned          cursor;
   bit                   matching;
   int unsigned          prefix_run;
   logic [TOTAL_W-1:0]   set_total;
   bit                   have_prior;
   bit                   dropped_chars;

   // run bookkeeping
   bit                   running;
   bit                   req_taken;
   int                   send_gap;
   int                   recv_gap;
   int                   stuck_cycles;
   int                   errors;
   int                   reported;
   int                   results_checked;
   int                   overflow_results;
   int                   strings_queued;
   int                   long_strings;
   int                   set_breaks;

   front_coding_size_counter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_last_of_string  (req_last_of_string),
      .req_starts_set      (req_starts_set),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_string_cost     (rsp_string_cost),
      .rsp_shared_prefix   (rsp_shared_prefix),
      .rsp_running_total   (rsp_running_total),
      .rsp_too_long        (rsp_too_long),
      .rsp_total_saturated (rsp_total_saturated)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clear the per-string predictor state
   function automatic void restart_string();
      cursor        = 0;
      matching      = 1'b1;
      prefix_run    = 0;
      dropped_chars = 1'b0;
   endfunction

   // Advance the cost predictor by one accepted character beat
   task automatic predict_cost(input logic [CHAR_W-1:0] ch, input bit last,
                               input bit start);
      cost_result_type   res;
      int unsigned       shared;
      int unsigned       cost;
      longint unsigned   sum;
      if (start) begin
         set_total  = '0;
         have_prior = 1'b0;
         restart_string();
      end
      if (cursor < STORE_DEPTH) begin
         if (matching && have_prior && cursor < prior_len && prior_chars[cursor] == ch)
            prefix_run++;
         else
            matching = 1'b0;
         prior_chars[cursor] = ch;
         cursor++;
      end else begin
         dropped_chars = 1'b1;
      end
      if (last) begin
         shared = have_prior ? prefix_run : 0;
         cost   = have_prior ? 1 + cursor - shared : cursor;
         sum    = longint'(set_total) + cost;
         if (sum > 64'hFFFF_FFFF)
            sum = 64'hFFFF_FFFF;
         set_total     = sum[TOTAL_W-1:0];
         res.cost      = cost[FIELD_W-1:0];
         res.prefix    = shared[FIELD_W-1:0];
         res.total     = set_total;
         res.too_long  = dropped_chars;
         res.saturated = (set_total == '1);
         cost_expect_q.push_back(res);
         prior_len  = cursor;
         have_prior = 1'b1;
         restart_string();
      end
   endtask

   function automatic void push_char(input logic [CHAR_W-1:0] code, input bit last,
                                     input bit start);
      char_beat_type b;
      b.code             = code;
      b.last             = last;
      b.start            = start;
      b.hold_until_empty = 1'b0;
      pending_chars.push_back(b);
   endfunction

   // Bias characters towards a few values so prefixes collide often
   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(0, 3))
         0: c = 8'h00;
         1: c = 8'hFF;
         2: c = CHAR_W'(8'h41 + $urandom_range(0, 2));
         default: c = CHAR_W'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // Queue one string that reuses a random prefix of the last complete one;
   // a broken string may stop early and has no last mark
   task automatic add_string(input int len, input bit new_set, input bit hold,
                             input bit broken);
      int                keep;
      int                stop;
      char_beat_type     b;
      logic [CHAR_W-1:0] made[$];
      keep = $urandom_range(0, shadow_string.size());
      if (keep > len)
         keep = len;
      stop = broken ? $urandom_range(1, len) : len;
      for (int i = 0; i < stop; i++) begin
         b.code             = (i < keep) ? shadow_string[i] : pick_char();
         b.last             = !broken && (i == len - 1);
         b.start            = new_set && (i == 0);
         b.hold_until_empty = hold && (i == 0);
         pending_chars.push_back(b);
         made.push_back(b.code);
      end
      if (!broken) begin
         shadow_string = made;
         strings_queued++;
         if (len > STORE_DEPTH)
            long_strings++;
      end else begin
         set_breaks++;
      end
   endtask

   // Drive the request channel and the response stall at the falling edge
   always @(negedge clock) begin : drive_chars
      char_beat_type nxt;
      bit         send;
      bit         quiet;
      bit         stall_now;
      quiet = pending_chars.size() < TAIL_ITEMS;
      send  = req_valid && !req_taken;
      if (!running) begin
         send = 1'b0;
      end else if (!send) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_chars.size() > 0) begin
            if (pending_chars[0].hold_until_empty && cost_expect_q.size() != 0) begin
               send = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 8) - 1;
            end else begin
               nxt                = pending_chars.pop_front();
               req_char_code      <= nxt.code;
               req_last_of_string <= nxt.last;
               req_starts_set     <= nxt.start;
               send               = 1'b1;
            end
         end
      end
      req_valid <= send;

      // stall the result channel in bursts, none in the tail
      if (!running || quiet) begin
         stall_now = 1'b0;
         recv_gap  = 0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         stall_now = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         recv_gap  = $urandom_range(1, 8) - 1;
         stall_now = 1'b1;
      end else begin
         stall_now = 1'b0;
      end
      rsp_stall <= stall_now;
   end

   // Predict on every accepted character beat and check every result beat
   always @(posedge clock) begin : watch_ports
      cost_result_type got;
      cost_result_type want;
      bit           moved;
      if (reset) begin
         req_taken    <= 1'b0;
         stuck_cycles = 0;
      end else begin
         moved = 1'b0;
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_cost(req_char_code, req_last_of_string, req_starts_set);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got.cost      = rsp_string_cost;
            got.prefix    = rsp_shared_prefix;
            got.total     = rsp_running_total;
            got.too_long  = rsp_too_long;
            got.saturated = rsp_total_saturated;
            if (cost_expect_q.size() == 0) begin
               errors++;
               if (reported < REPORT_MAX) begin
                  reported++;
                  $display("%0t: result beat with nothing expected: cost %0d prefix %0d",
                           $realtime, got.cost, got.prefix);
               end
            end else begin
               want = cost_expect_q.pop_front();
               results_checked++;
               if (want.too_long)
                  overflow_results++;
               if (got.cost !== want.cost || got.prefix !== want.prefix ||
                   got.total !== want.total || got.too_long !== want.too_long ||
                   got.saturated !== want.saturated) begin
                  errors++;
                  if (reported < REPORT_MAX) begin
                     reported++;
                     $display("%0t: mismatch exp cost %0d prefix %0d total %0d long %0b sat %0b",
                              $realtime, want.cost, want.prefix, want.total,
                              want.too_long, want.saturated);
                     $display("%0t:          got cost %0d prefix %0d total %0d long %0b sat %0b",
                              $realtime, got.cost, got.prefix, got.total,
                              got.too_long, got.saturated);
                  end
               end
            end
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
      end
   end

   initial begin : run_test
      int  len;
      int  pick;
      int  forced;
      bit  hold_done;
      bit  next_new_set;
      bit  broken;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_char_code      = '0;
      req_last_of_string = 1'b0;
      req_starts_set     = 1'b0;
      rsp_stall          = 1'b0;
      running            = 1'b0;
      send_gap           = 0;
      recv_gap           = 0;
      errors             = 0;
      reported           = 0;
      results_checked    = 0;
      overflow_results   = 0;
      strings_queued     = 0;
      long_strings       = 0;
      set_breaks         = 0;
      prior_len          = 0;
      set_total          = '0;
      have_prior         = 1'b0;
      restart_string();

      // directed: first string after reset, no set start
      push_char(8'h41, 1'b1, 1'b0);
      // new set, then extreme characters with growing and shrinking prefixes
      push_char(8'h00, 1'b1, 1'b1);
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(8'hFF, 1'b0, 1'b0);
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'hFF, 1'b0, 1'b0);
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(8'hFF, 1'b0, 1'b0);
      push_char(8'h00, 1'b0, 1'b0);
      push_char(8'h07, 1'b1, 1'b0);
      // set start in mid-string drops the partial string
      push_char(8'h01, 1'b0, 1'b0);
      push_char(8'h02, 1'b0, 1'b0);
      push_char(8'h03, 1'b0, 1'b1);
      push_char(8'h04, 1'b1, 1'b0);
      push_char(8'h03, 1'b0, 1'b0);
      push_char(8'h04, 1'b0, 1'b0);
      push_char(8'h05, 1'b1, 1'b0);
      // one-character string that both starts a set and ends
      push_char(8'h03, 1'b1, 1'b1);
      strings_queued = 10;
      set_breaks     = 1;

      // random strings: mostly short, some medium, a few past the store size
      forced       = 0;
      hold_done    = 1'b0;
      next_new_set = 1'b0;
      while (pending_chars.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (forced < 2) begin
            len = STORE_DEPTH + forced;
            forced++;
         end else if (pick < 4) begin
            len = $urandom_range(240, 300);
         end else if (pick < 14) begin
            len = $urandom_range(13, 64);
         end else begin
            len = $urandom_range(1, 12);
         end
         broken = ($urandom_range(0, 19) == 0);
         add_string(len, next_new_set || $urandom_range(0, 9) == 0,
                    !hold_done && pending_chars.size() >= RANDOM_ITEMS / 2, broken);
         if (!hold_done && pending_chars.size() >= RANDOM_ITEMS / 2)
            hold_done = 1'b1;
         next_new_set = broken;
      end
      // close any broken string with a complete one
      if (next_new_set)
         add_string($urandom_range(1, 12), 1'b1, 1'b0, 1'b0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      running <= 1'b1;

      // wait for all beats to go in and all results to come out
      while (pending_chars.size() > 0 || req_valid || cost_expect_q.size() > 0) begin
         @(posedge clock);
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("front_coding_size_counter regression: fail");
            $finish;
         end
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += cost_expect_q.size();

      $display("Ran %0d strings (%0d over the store size, %0d cut short by a set start).",
               strings_queued, long_strings, set_breaks);
      $display("Checked %0d results, %0d of them with dropped characters; %0d errors.",
               results_checked, overflow_results, errors);
      if (errors == 0) begin
         $display("front_coding_size_counter regression: pass");
      end else begin
         $display("front_coding_size_counter regression: fail");
      end
      $finish;
   end

endmodule

// ----- front_coding_size_counter.f -----
rtl/fcsc_pkg.sv
rtl/fcsc_ram.sv
rtl/fcsc_front.sv
rtl/fcsc_queue.sv
rtl/fcsc_back.sv
rtl/front_coding_size_counter.sv
tb/front_coding_size_counter_tb.sv
